// ===== rtl/bcf_pkg.sv =====
// Shared types, constants and codes of the Bezier curve flattener.
// No dependencies.
`default_nettype none
package bcf_pkg;

  localparam int CW  = 20;   // coordinate width, Q16.4
  localparam int QW  = 23;   // step-term quotient width
  localparam int STW = 24;   // step width
  localparam int TW  = 25;   // t accumulator width
  localparam int WW  = 49;   // Bernstein weight width
  localparam int AW  = 70;   // product / accumulator width
  localparam int DW  = 21;   // distance width

  localparam int ONE_T_INT = 65536;
  localparam logic [16:0] ONE_T = 17'h10000;
  localparam logic [QW-1:0] STEP_NUM = 23'd5242880;  // 5 << 20
  localparam int MAX_POINTS_DEF = 64;

  localparam logic [1:0] CMD_QUAD  = 2'd0;
  localparam logic [1:0] CMD_CUBIC = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] MA_MT = 2'd0;
  localparam logic [1:0] MA_T  = 2'd1;
  localparam logic [1:0] MA_W  = 2'd2;

  localparam logic [1:0] MB_MT = 2'd0;
  localparam logic [1:0] MB_T  = 2'd1;
  localparam logic [1:0] MB_P  = 2'd2;

  localparam logic [1:0] SC1 = 2'd0;
  localparam logic [1:0] SC2 = 2'd1;
  localparam logic [1:0] SC3 = 2'd2;

  localparam logic [1:0] OS_START = 2'd0;
  localparam logic [1:0] OS_END   = 2'd1;
  localparam logic [1:0] OS_CALC  = 2'd2;

  typedef struct packed {
    logic       wr;      // write scaled product to weight d_idx
    logic       mac;     // product goes to accumulator
    logic       first;
    logic       last;
    logic       y;
    logic [1:0] ma;
    logic [1:0] mb;
    logic [1:0] a_idx;
    logic [1:0] p_idx;
    logic [1:0] d_idx;
    logic [1:0] scale;
  } bcf_uop_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_sel_y;
    logic       add_step;
    logic       step_fix;
    logic       t_clr;
    logic       t_adv;
    bcf_uop_t   uop;
    logic       out_load;
    logic [1:0] out_src;
    logic       out_last;
  } bcf_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       zero;
    logic       div_busy;
    logic       pt_ready;
    logic       out_free;
    logic       t_over;
  } bcf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/bcf_div.sv =====
// Restoring divider of the constant step numerator by a distance, one bit a cycle.
// Depends on bcf_pkg.
`default_nettype none
module bcf_div
  import bcf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] den,
  output logic     [QW-1:0]  quot,
  output logic               busy
);

  logic [DW-1:0] dreg;
  logic [DW-1:0] rem;
  logic [4:0]    cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, STEP_NUM[cnt]};
  assign diff  = trial - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= den;
      rem  <= '0;
      quot <= '0;
      cnt  <= 5'(QW - 1);
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem       <= diff[DW-1:0];
        quot[cnt] <= 1'b1;
      end else begin
        rem <= trial[DW-1:0];
      end
      cnt <= cnt - 5'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bcf_dp.sv =====
// Datapath: segment registers, step divider, t accumulator, shared multiplier,
// Bernstein accumulator and output register. Depends on bcf_pkg, bcf_div.
`default_nettype none
module bcf_dp
  import bcf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire bcf_cmd_t     c,
  output bcf_stat_t         st,
  input  wire logic [159:0] s_tdata,
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,
  output logic [0:0]        m_tuser,
  output logic              m_tlast
);

  localparam logic [STW-1:0] MIN_STEP = STW'(ONE_T_INT / (MAX_POINTS - 1));

  logic [1:0]           kind;
  logic signed [CW-1:0] crd [8];   // sx sy ax ay bx by ex ey
  logic [STW-1:0]       step;
  logic                 clamped;
  logic [TW-1:0]        t;
  logic [WW-1:0]        w [4];
  logic signed [AW-1:0] prod_r, acc;
  logic                 mac_d, first_d, last_d, y_d, fin_d, fin_y;
  logic signed [CW-1:0] rx, ry;
  logic                 pt_ready;

  logic signed [DW-1:0] sdx, sdy;
  logic [DW-1:0]        adx, ady;
  logic [QW-1:0]        quot;
  logic                 div_busy;
  logic [16:0]          mt;
  logic [WW-1:0]        a_op;
  logic signed [CW-1:0] b_op;
  logic signed [WW:0]   a_s;
  logic signed [AW-1:0] prod, scaled, rsum;
  logic [TW-1:0]        t_next;
  logic                 out_free;

  assign sdx = DW'(crd[6]) - DW'(crd[0]);
  assign sdy = DW'(crd[7]) - DW'(crd[1]);
  assign adx = sdx[DW-1] ? DW'(-sdx) : DW'(sdx);
  assign ady = sdy[DW-1] ? DW'(-sdy) : DW'(sdy);

  bcf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (c.div_start),
    .den   (c.div_sel_y ? ady : adx),
    .quot  (quot),
    .busy  (div_busy)
  );

  assign mt     = ONE_T - t[16:0];
  assign t_next = t + TW'(step);

  always_comb begin
    unique case (c.uop.ma)
      MA_MT:   a_op = WW'(mt);
      MA_T:    a_op = WW'(t[16:0]);
      default: a_op = w[c.uop.a_idx];
    endcase
    unique case (c.uop.mb)
      MB_MT:   b_op = CW'(mt);
      MB_T:    b_op = CW'(t[16:0]);
      default: b_op = crd[{c.uop.p_idx, c.uop.y}];
    endcase
  end

  assign a_s  = {1'b0, a_op};
  assign prod = a_s * b_op;

  always_comb begin
    unique case (c.uop.scale)
      SC2:     scaled = prod <<< 1;
      SC3:     scaled = prod + (prod <<< 1);
      default: scaled = prod;
    endcase
  end

  assign rsum = acc + ((kind == CMD_CUBIC) ? (AW'(1) <<< 47) : (AW'(1) <<< 31));

  always_ff @(posedge clk) begin
    if (c.load) begin
      kind <= s_tuser;
      for (int i = 0; i < 8; i++) begin
        crd[i] <= s_tdata[i*CW +: CW];
      end
      step    <= '0;
      clamped <= 1'b0;
    end else if (c.add_step) begin
      step <= step + STW'(quot);
    end else if (c.step_fix && step < MIN_STEP) begin
      step    <= MIN_STEP;
      clamped <= 1'b1;
    end
    if (c.t_clr) begin
      t <= '0;
    end else if (c.t_adv) begin
      t <= t_next;
    end
    if (c.uop.wr) begin
      w[c.uop.d_idx] <= scaled[WW-1:0];
    end
    prod_r  <= prod;
    first_d <= c.uop.first;
    last_d  <= c.uop.last;
    y_d     <= c.uop.y;
    fin_y   <= y_d;
    if (mac_d) begin
      acc <= first_d ? prod_r : acc + prod_r;
    end
    if (fin_d) begin
      if (fin_y) begin
        ry <= rsum[CW+47:48] & {CW{kind == CMD_CUBIC}} |
              rsum[CW+31:32] & {CW{kind != CMD_CUBIC}};
      end else begin
        rx <= rsum[CW+47:48] & {CW{kind == CMD_CUBIC}} |
              rsum[CW+31:32] & {CW{kind != CMD_CUBIC}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_d    <= 1'b0;
      fin_d    <= 1'b0;
      pt_ready <= 1'b0;
    end else begin
      mac_d <= c.uop.mac;
      fin_d <= mac_d && last_d;
      if (fin_d && fin_y) begin
        pt_ready <= 1'b1;
      end else if (c.out_load && c.out_src == OS_CALC) begin
        pt_ready <= 1'b0;
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (c.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.out_load) begin
      m_tlast <= c.out_last;
      unique case (c.out_src)
        OS_START: begin
          m_tdata <= {crd[1], crd[0]};
          m_tuser <= 1'b0;
        end
        OS_END: begin
          m_tdata <= {crd[7], crd[6]};
          m_tuser <= 1'b0;
        end
        default: begin
          m_tdata <= {ry, rx};
          m_tuser <= clamped;
        end
      endcase
    end
  end

  always_comb begin
    st.kind     = kind;
    st.zero     = (adx == '0) || (ady == '0);
    st.div_busy = div_busy;
    st.pt_ready = pt_ready;
    st.out_free = out_free;
    st.t_over   = t_next > TW'(ONE_T);
  end

endmodule
`default_nettype wire

// ===== rtl/bcf_ctrl.sv =====
// Controller: segment decode, step division sequencing and per-point microcode.
// Depends on bcf_pkg.
`default_nettype none
module bcf_ctrl
  import bcf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire logic      endpoints_only,
  input  wire bcf_stat_t st,
  output bcf_cmd_t       c
);

  localparam int NW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_EP0  = 4'd2;
  localparam logic [3:0] S_EP1  = 4'd3;
  localparam logic [3:0] S_ZERO = 4'd4;
  localparam logic [3:0] S_DIVX = 4'd5;
  localparam logic [3:0] S_DIVY = 4'd6;
  localparam logic [3:0] S_FIX  = 4'd7;
  localparam logic [3:0] S_EVAL = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]    state, state_next;
  logic [3:0]    ph, ph_next;
  logic [NW-1:0] n, n_next;
  logic          cubic;
  logic [3:0]    ph_end;
  logic          pt_last;

  function automatic bcf_uop_t wop(input logic [1:0] ma, input logic [1:0] mb,
                                   input logic [1:0] ai, input logic [1:0] di,
                                   input logic [1:0] sc);
    bcf_uop_t u;
    u       = '0;
    u.wr    = 1'b1;
    u.ma    = ma;
    u.mb    = mb;
    u.a_idx = ai;
    u.d_idx = di;
    u.scale = sc;
    return u;
  endfunction

  function automatic bcf_uop_t mop(input logic [1:0] ai, input logic [1:0] pi,
                                   input logic y, input logic f, input logic l);
    bcf_uop_t u;
    u       = '0;
    u.mac   = 1'b1;
    u.ma    = MA_W;
    u.mb    = MB_P;
    u.a_idx = ai;
    u.p_idx = pi;
    u.y     = y;
    u.first = f;
    u.last  = l;
    u.scale = SC1;
    return u;
  endfunction

  assign cubic   = st.kind == CMD_CUBIC;
  assign ph_end  = cubic ? 4'd13 : 4'd8;
  assign pt_last = st.t_over || n == NW'(MAX_POINTS - 1);
  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    ph_next    = ph;
    n_next     = n;
    c          = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          c.load     = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (st.kind == CMD_NONE) begin
          state_next = S_IDLE;
        end else if (st.kind == CMD_LINE || endpoints_only) begin
          state_next = S_EP0;
        end else if (st.zero) begin
          state_next = S_ZERO;
        end else begin
          c.div_start = 1'b1;
          state_next  = S_DIVX;
        end
      end
      S_EP0: begin
        if (st.out_free) begin
          c.out_load = 1'b1;
          c.out_src  = OS_START;
          state_next = S_EP1;
        end
      end
      S_EP1: begin
        if (st.out_free) begin
          c.out_load = 1'b1;
          c.out_src  = OS_END;
          c.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ZERO: begin
        if (st.out_free) begin
          c.out_load = 1'b1;
          c.out_src  = OS_START;
          c.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIVX: begin
        if (!st.div_busy) begin
          c.add_step  = 1'b1;
          c.div_start = 1'b1;
          c.div_sel_y = 1'b1;
          state_next  = S_DIVY;
        end
      end
      S_DIVY: begin
        c.div_sel_y = 1'b1;
        if (!st.div_busy) begin
          c.add_step = 1'b1;
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        c.step_fix = 1'b1;
        c.t_clr    = 1'b1;
        n_next     = '0;
        ph_next    = '0;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (cubic) begin
          unique case (ph)
            4'd0:    c.uop = wop(MA_MT, MB_MT, 2'd0, 2'd0, SC1);
            4'd1:    c.uop = wop(MA_T,  MB_T,  2'd0, 2'd2, SC1);
            4'd2:    c.uop = wop(MA_W,  MB_T,  2'd2, 2'd3, SC1);
            4'd3:    c.uop = wop(MA_W,  MB_T,  2'd0, 2'd1, SC3);
            4'd4:    c.uop = wop(MA_W,  MB_MT, 2'd0, 2'd0, SC1);
            4'd5:    c.uop = wop(MA_W,  MB_MT, 2'd2, 2'd2, SC3);
            4'd6:    c.uop = mop(2'd0, 2'd0, 1'b0, 1'b1, 1'b0);
            4'd7:    c.uop = mop(2'd1, 2'd1, 1'b0, 1'b0, 1'b0);
            4'd8:    c.uop = mop(2'd2, 2'd2, 1'b0, 1'b0, 1'b0);
            4'd9:    c.uop = mop(2'd3, 2'd3, 1'b0, 1'b0, 1'b1);
            4'd10:   c.uop = mop(2'd0, 2'd0, 1'b1, 1'b1, 1'b0);
            4'd11:   c.uop = mop(2'd1, 2'd1, 1'b1, 1'b0, 1'b0);
            4'd12:   c.uop = mop(2'd2, 2'd2, 1'b1, 1'b0, 1'b0);
            4'd13:   c.uop = mop(2'd3, 2'd3, 1'b1, 1'b0, 1'b1);
            default: c.uop = '0;
          endcase
        end else begin
          unique case (ph)
            4'd0:    c.uop = wop(MA_MT, MB_MT, 2'd0, 2'd0, SC1);
            4'd1:    c.uop = wop(MA_MT, MB_T,  2'd0, 2'd1, SC2);
            4'd2:    c.uop = wop(MA_T,  MB_T,  2'd0, 2'd2, SC1);
            4'd3:    c.uop = mop(2'd0, 2'd0, 1'b0, 1'b1, 1'b0);
            4'd4:    c.uop = mop(2'd1, 2'd1, 1'b0, 1'b0, 1'b0);
            4'd5:    c.uop = mop(2'd2, 2'd3, 1'b0, 1'b0, 1'b1);
            4'd6:    c.uop = mop(2'd0, 2'd0, 1'b1, 1'b1, 1'b0);
            4'd7:    c.uop = mop(2'd1, 2'd1, 1'b1, 1'b0, 1'b0);
            4'd8:    c.uop = mop(2'd2, 2'd3, 1'b1, 1'b0, 1'b1);
            default: c.uop = '0;
          endcase
        end
        ph_next = ph + 4'd1;
        if (ph == ph_end) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.pt_ready && st.out_free) begin
          c.out_load = 1'b1;
          c.out_src  = OS_CALC;
          c.out_last = pt_last;
          c.t_adv    = 1'b1;
          ph_next    = '0;
          n_next     = n + NW'(1);
          state_next = pt_last ? S_IDLE : S_EVAL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      n     <= n_next;
    end
  end

`ifndef SYNTHESIS
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    c.out_load |-> st.out_free) else $error("output overwritten");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (c.div_start && state == S_DEC) |-> !st.div_busy) else $error("divider restarted");
  a_max_pts: assert property (@(posedge clk) disable iff (rst)
    (c.out_load && c.out_src == OS_CALC && n == NW'(MAX_POINTS - 1)) |-> c.out_last)
    else $error("point count overrun");
`endif

endmodule
`default_nettype wire

// ===== rtl/bezier_curve_flattener.sv =====
// Bezier segment flattener top level: APB configuration, controller and datapath.
// Depends on bcf_pkg, bcf_ctrl, bcf_dp.
// Lines, endpoints-only and segments with a zero x or y distance skip the step division;
//   curves run two 23-bit step divisions before their first point.
// Points are then evaluated one at a time on one shared multiplier; output waits on m_tready.
// Reset: synchronous, active high; clears control state and endpoints_only.
`default_nettype none
module bezier_curve_flattener
  import bcf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
  input  wire logic [159:0] s_tdata,
  // cmd
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // point_x, point_y
  output logic [39:0]       m_tdata,
  // step_clamped
  output logic [0:0]        m_tuser,
  output logic              m_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic      endpoints_only;
  bcf_cmd_t  c;
  bcf_stat_t st;

  assign pready = 1'b1;
  assign prdata = {31'd0, endpoints_only & !paddr[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      endpoints_only <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      endpoints_only <= pwdata[0];
    end
  end

  bcf_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .endpoints_only (endpoints_only),
    .st             (st),
    .c              (c)
  );

  bcf_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .c        (c),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
